### hw/rtl/pipct_pkg.sv
// Shared types and constants for the point-in-polygon crossing test core.
package pipct_pkg;

    localparam int COORD_W = 32;
    localparam int IDX_W   = 8;
    localparam int VC_W    = 9;

    localparam logic [VC_W-1:0] VC_RESET = 9'd4;
    localparam int unsigned     EDGE_TOL = 17;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] LOC_OUTSIDE  = 2'd0;
    localparam logic [1:0] LOC_INSIDE   = 2'd1;
    localparam logic [1:0] LOC_BOUNDARY = 2'd2;

    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic                       op;
        logic [IDX_W-1:0]           idx;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_WALK,
        ENG_DRAIN,
        ENG_DONE
    } eng_state_t;

endpackage

### hw/rtl/pipct_front.sv
// Front end: accepts beats into a short queue ahead of the edge engine.
module pipct_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pipct_pkg::item_t s_item,
    output pipct_pkg::head_t head,
    input  logic             pop
);
    import pipct_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    item_t         fifo_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          push, do_pop;

    assign s_ready = (count_reg != (PW+1)'(DEPTH));
    assign push    = s_valid && s_ready;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule

### hw/rtl/pipct_engine.sv
// Back end: vertex store, pipelined edge walk and result register.
module pipct_engine #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pipct_pkg::head_t            head,
    output logic                        pop,
    input  logic [pipct_pkg::VC_W-1:0]  vertex_count,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_location
);
    import pipct_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = (CW > VC_W) ? CW : VC_W;
    // one bit above the store address so the range check sees the full depth
    localparam int IW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;

    eng_state_t state_reg, state_next;

    logic [2*COORD_W-1:0] mem [MAX_VERTICES];

    logic [NW-1:0] n_eff;
    logic [NW-1:0] walk_reg, walk_next;
    logic [IW-1:0] widx;

    // query point
    logic signed [COORD_W-1:0] qx_reg, qy_reg;

    // read stage
    logic                      rd_v_reg;
    logic [NW-1:0]             rd_idx_reg;
    logic signed [COORD_W-1:0] rd_x_reg, rd_y_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, y0ref_reg;

    // per-query accumulators
    logic parity_reg, bnd_reg, up_reg, ld_reg, e0_pend_reg, e0_up_reg, short_reg;

    // multiply pipeline
    logic               m_v_reg, p_v_reg, n_v_reg;
    logic signed [32:0] da_reg, db_reg, dc_reg, dd_reg;
    logic signed [65:0] p1_reg, p2_reg;
    logic signed [66:0] num_reg;
    logic [36:0]        lim_p_reg, lim_n_reg;
    logic               neg_p_reg, neg_n_reg;

    logic       out_v_reg;
    logic [1:0] out_loc_reg;

    // control outputs
    logic start_q, do_write, issue, load_out;

    // edge evaluation terms
    logic signed [COORD_W-1:0] x0, y0, x1, y1, xmin, xmax, ymin, ymax;
    logic edge_v, yin, in_x, right, vert, vcross, edge0, up_new, e_bnd, e_cross;
    logic n_cross, n_bnd;
    logic signed [66:0] lim_s;
    logic [32:0] dd_abs;

    assign n_eff = (NW'(vertex_count) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                          : NW'(vertex_count);
    assign widx  = IW'(head.item.idx);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE: begin
                if (head.valid && head.item.op == OP_QUERY) begin
                    state_next = (n_eff < NW'(2)) ? ENG_DONE : ENG_WALK;
                end
            end
            ENG_WALK: begin
                if (walk_reg == n_eff - 1'b1) state_next = ENG_DRAIN;
            end
            ENG_DRAIN: begin
                if (!rd_v_reg && !m_v_reg && !p_v_reg && !n_v_reg) state_next = ENG_DONE;
            end
            ENG_DONE: begin
                if (!out_v_reg || m_ready) state_next = ENG_IDLE;
            end
            default: state_next = ENG_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        start_q  = 1'b0;
        do_write = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        pop      = 1'b0;
        unique case (state_reg)
            ENG_IDLE: begin
                if (head.valid) begin
                    pop = 1'b1;
                    if (head.item.op == OP_QUERY) start_q = 1'b1;
                    else                          do_write = (widx < IW'(MAX_VERTICES));
                end
            end
            ENG_WALK:  issue = 1'b1;
            ENG_DRAIN: ;
            ENG_DONE:  load_out = !out_v_reg || m_ready;
            default: ;
        endcase
    end

    assign walk_next = issue ? walk_reg + 1'b1 : (start_q ? '0 : walk_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ENG_IDLE;
            walk_reg  <= '0;
            rd_v_reg  <= 1'b0;
            m_v_reg   <= 1'b0;
            p_v_reg   <= 1'b0;
            n_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            rd_v_reg  <= issue;
            m_v_reg   <= edge_v && yin && in_x;
            p_v_reg   <= m_v_reg;
            n_v_reg   <= p_v_reg;
            if (load_out)     out_v_reg <= 1'b1;
            else if (m_ready) out_v_reg <= 1'b0;
        end
    end

    // vertex store
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[widx[AW-1:0]] <= {head.item.x, head.item.y};
        end
        if (issue) begin
            {rd_x_reg, rd_y_reg} <= mem[walk_reg[AW-1:0]];
        end
    end

    // edge evaluation on the vertex just read and the one before it
    always_comb begin
        x0     = prev_x_reg;
        y0     = prev_y_reg;
        x1     = rd_x_reg;
        y1     = rd_y_reg;
        xmin   = (x0 < x1) ? x0 : x1;
        xmax   = (x0 < x1) ? x1 : x0;
        ymin   = (y0 < y1) ? y0 : y1;
        ymax   = (y0 < y1) ? y1 : y0;
        edge_v = rd_v_reg && (rd_idx_reg != '0);
        edge0  = (rd_idx_reg == NW'(1));
        yin    = (qy_reg < ymax) && (qy_reg > ymin);
        in_x   = (qx_reg >= xmin) && (qx_reg <= xmax);
        right  = qx_reg > xmax;
        vert   = !yin && (qy_reg == y0);
        up_new = (y0 < y1) ? 1'b1 : ((y0 > y1) ? 1'b0 : up_reg);
        vcross = vert && (qx_reg != x0) && (y0 != y1) && (qx_reg > x0);
        e_bnd  = edge_v && vert && ((qx_reg == x0) || ((y0 == y1) && in_x));
        e_cross = edge_v && ((yin && right) || (vcross && !edge0 && (up_new == up_reg)));

        lim_s   = 67'(lim_n_reg);
        n_cross = n_v_reg && (neg_n_reg ? (num_reg > 67'sd0) : (num_reg < 67'sd0));
        n_bnd   = n_v_reg && (num_reg < lim_s) && (num_reg > -lim_s);
        dd_abs  = dd_reg[32] ? 33'(-dd_reg) : 33'(dd_reg);
    end

    always_ff @(posedge aclk) begin
        if (start_q) begin
            qx_reg      <= head.item.x;
            qy_reg      <= head.item.y;
            parity_reg  <= 1'b0;
            bnd_reg     <= 1'b0;
            up_reg      <= 1'b0;
            ld_reg      <= 1'b0;
            e0_pend_reg <= 1'b0;
            e0_up_reg   <= 1'b0;
            short_reg   <= (n_eff < NW'(2));
        end else begin
            parity_reg <= parity_reg ^ e_cross ^ n_cross;
            bnd_reg    <= bnd_reg | e_bnd | n_bnd;
            if (edge_v) up_reg <= up_new;
            if (edge_v && edge0) begin
                e0_pend_reg <= vcross;
                e0_up_reg   <= up_new;
            end
            // latest vertex below the closing one whose y differs from vertex 0
            if (rd_v_reg && rd_idx_reg != '0 && (rd_idx_reg + 1'b1 < n_eff)
                && rd_y_reg != y0ref_reg) begin
                ld_reg <= y0ref_reg > rd_y_reg;
            end
        end
        rd_idx_reg <= walk_reg;
        if (rd_v_reg) begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
            if (rd_idx_reg == '0) y0ref_reg <= rd_y_reg;
        end
        da_reg    <= 33'(qy_reg) - 33'(y0);
        db_reg    <= 33'(x1) - 33'(x0);
        dc_reg    <= 33'(qx_reg) - 33'(x0);
        dd_reg    <= 33'(y1) - 33'(y0);
        p1_reg    <= da_reg * db_reg;
        p2_reg    <= dc_reg * dd_reg;
        lim_p_reg <= {4'b0, dd_abs} + {dd_abs, 4'b0};
        neg_p_reg <= dd_reg[32];
        num_reg   <= 67'(p1_reg) - 67'(p2_reg);
        lim_n_reg <= lim_p_reg;
        neg_n_reg <= neg_p_reg;
        if (load_out) begin
            if (short_reg)    out_loc_reg <= LOC_OUTSIDE;
            else if (bnd_reg) out_loc_reg <= LOC_BOUNDARY;
            else if (parity_reg ^ (e0_pend_reg && (e0_up_reg == ld_reg)))
                              out_loc_reg <= LOC_INSIDE;
            else              out_loc_reg <= LOC_OUTSIDE;
        end
    end

    assign m_valid    = out_v_reg;
    assign m_location = out_loc_reg;

endmodule

### hw/rtl/point_in_polygon_crossing_test_core.sv
// A query leaves the queue, walks the edges, drains the multiply pipeline and then loads the result register.
// Vertex writes are taken from the queue while idle; edges stream one per cycle from the single-port vertex store.
// Queries are handled one at a time; a 4-deep queue buffers input beats while one is in progress.
// Reset (aresetn, synchronous, active low) empties the queue and result register and sets
// vertex_count to 4; vertex store contents are undefined until written.
module point_in_polygon_crossing_test_core #(
    parameter int MAX_VERTICES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_vertex_index,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_location,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pipct_pkg::*;

    logic [VC_W-1:0] vc_reg;
    item_t           s_item;
    head_t           head;
    logic            pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {23'b0, vc_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= VC_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
            vc_reg <= pwdata[VC_W-1:0];
        end
    end

    assign s_item.op  = s_operation;
    assign s_item.idx = s_vertex_index;
    assign s_item.x   = s_coord_x;
    assign s_item.y   = s_coord_y;

    pipct_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .head    (head),
        .pop     (pop)
    );

    pipct_engine #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .pop          (pop),
        .vertex_count (vc_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_location   (m_location)
    );

endmodule

### hw/rtl/pipct_checker.sv
// Port-level checks for the crossing test core, bound to the top level.
module pipct_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_location,
    input logic       pready
);
    import pipct_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_location))
        else $error("result beat dropped or changed while stalled");

    a_loc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_location == LOC_OUTSIDE || m_location == LOC_INSIDE ||
                     m_location == LOC_BOUNDARY))
        else $error("illegal location code");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind point_in_polygon_crossing_test_core pipct_checker u_pipct_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_location (m_location),
    .pready     (pready)
);
